// ===== sv/idct_pkg.sv =====
// shared types, constants and the folded idct coefficient table for the 8x8 integer idct
// no dependencies
package idct_pkg;

  localparam int CoeffW  = 12;
  localparam int SampleW = 16;
  localparam int RowW    = 20;
  localparam int FifoDepthDefault = 4;

  localparam int ConstBits = 13;
  localparam int PassBits  = 2;
  localparam int RowShift  = ConstBits - PassBits;
  localparam int ColShift  = ConstBits + PassBits + 3;

  localparam int AccW = 40;

  typedef struct packed {
    logic signed [CoeffW-1:0] coeff_value;
    logic [5:0]               position;
    logic                     end_block;
  } in_item_t;

  typedef struct packed {
    logic signed [SampleW-1:0] sample;
    logic                      last_sample;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE, ST_ROWS, ST_COLS, ST_EMIT
  } eng_state_t;

  typedef logic signed [AccW-1:0] acc_t;
  typedef logic signed [15:0]     coef_t;
  typedef coef_t [0:7]            coef_row_t;

  // loeffler butterfly folded into one integer matrix, 2^13 scale, no descale
  // row k gives output k, entry n weights input n
  function automatic coef_t idct_coef(input logic [2:0] k, input logic [2:0] n);
    coef_row_t row;
    unique case (k)
      3'd0: row = {16'sd8192, 16'sd11363, 16'sd10703, 16'sd9633,
                   16'sd8192, 16'sd6437, 16'sd4433, 16'sd2260};
      3'd1: row = {16'sd8192, 16'sd9633, 16'sd4433, -16'sd2259,
                   -16'sd8192, -16'sd11362, -16'sd10704, -16'sd6436};
      3'd2: row = {16'sd8192, 16'sd6437, -16'sd4433, -16'sd11362,
                   -16'sd8192, 16'sd2261, 16'sd10704, 16'sd9633};
      3'd3: row = {16'sd8192, 16'sd2260, -16'sd10703, -16'sd6436,
                   16'sd8192, 16'sd9633, -16'sd4433, -16'sd11363};
      3'd4: row = {16'sd8192, -16'sd2260, -16'sd10703, 16'sd6436,
                   16'sd8192, -16'sd9633, -16'sd4433, 16'sd11363};
      3'd5: row = {16'sd8192, -16'sd6437, -16'sd4433, 16'sd11362,
                   -16'sd8192, -16'sd2261, 16'sd10704, -16'sd9633};
      3'd6: row = {16'sd8192, -16'sd9633, 16'sd4433, 16'sd2259,
                   -16'sd8192, 16'sd11362, -16'sd10704, 16'sd6436};
      3'd7: row = {16'sd8192, -16'sd11363, 16'sd10703, -16'sd9633,
                   16'sd8192, -16'sd6437, 16'sd4433, -16'sd2260};
    endcase
    return row[n];
  endfunction

endpackage

// ===== sv/idct_front.sv =====
// input side: accepts coefficient writes into a short queue
// depends on idct_pkg
module idct_front import idct_pkg::*; #(
  parameter int Depth = FifoDepthDefault
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  output logic     full,
  input  in_item_t in_data,
  output logic     q_valid,
  input  logic     q_take,
  output in_item_t q_data
);
  localparam int AW = $clog2(Depth);

  in_item_t        mem [Depth];
  logic [AW-1:0]   wr_ptr, rd_ptr;
  logic [AW:0]     count;
  logic            do_push, do_pop;

  assign full    = (count == (AW+1)'(Depth));
  assign q_valid = (count != '0);
  assign q_data  = mem[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = q_take && q_valid;

  // queue storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= in_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == AW'(Depth-1)) ? '0 : wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= (rd_ptr == AW'(Depth-1)) ? '0 : rd_ptr + 1'b1;
      count <= count + (AW+1)'(do_push) - (AW+1)'(do_pop);
    end
  end
endmodule

// ===== sv/idct_engine.sv =====
// back side: coefficient store, row and column passes on one shared mac, sample output
// depends on idct_pkg
module idct_engine import idct_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      q_valid,
  output logic      q_take,
  input  in_item_t  q_data,
  output logic      empty,
  input  logic      pop,
  output out_item_t out_data
);
  localparam int         ProdW  = RowW + 16;
  localparam logic [3:0] PhLast = 4'd9;

  eng_state_t state, state_next;

  logic signed [CoeffW-1:0]  cstore [64];
  logic [63:0]               cvalid;
  logic signed [RowW-1:0]    rstore [64];
  logic [5:0]                oidx;     // output index, row-major
  logic [3:0]                ph;       // phase within one output
  logic [5:0]                caddr, raddr;
  logic signed [RowW-1:0]    rd_data;
  logic [2:0]                rd_n;
  logic [2:0]                ck;
  coef_t                     coef;
  logic signed [ProdW-1:0]   prod;
  acc_t                      acc, row_round, col_round;
  logic signed [SampleW-1:0] col_sat, out_sample;
  logic                      mac_en, row_done, col_done;

  // operand addresses: row pass walks a row, column pass walks a column
  assign caddr = {oidx[5:3], ph[2:0]};
  assign raddr = {ph[2:0], oidx[2:0]};
  assign ck    = (state == ST_ROWS) ? oidx[2:0] : oidx[5:3];
  assign coef  = idct_coef(ck, rd_n);

  // 20 x 16 signed product
  assign prod = ProdW'(rd_data) * ProdW'(coef);

  assign mac_en   = (state == ST_ROWS || state == ST_COLS) && ph != 4'd0 && ph != PhLast;
  assign row_done = (state == ST_ROWS) && (ph == PhLast);
  assign col_done = (state == ST_COLS) && (ph == PhLast);

  // round, descale and saturate
  always_comb begin
    row_round = (acc + (acc_t'(1) <<< (RowShift-1))) >>> RowShift;
    col_round = (acc + (acc_t'(1) <<< (ColShift-1))) >>> ColShift;
    if (col_round > acc_t'(32767))       col_sat = 16'sh7fff;
    else if (col_round < acc_t'(-32768)) col_sat = 16'sh8000;
    else                                 col_sat = col_round[SampleW-1:0];
  end

  // sequencer
  always_comb begin
    state_next = state;
    q_take = 1'b0;
    unique case (state)
      ST_IDLE: begin
        q_take = q_valid;
        if (q_valid && q_data.end_block) state_next = ST_ROWS;
      end
      ST_ROWS: if (row_done && oidx == 6'd63) state_next = ST_COLS;
      ST_COLS: if (col_done) state_next = ST_EMIT;
      ST_EMIT: begin
        if (pop) state_next = (oidx == 6'd63) ? ST_IDLE : ST_COLS;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign empty = (state != ST_EMIT);
  assign out_data.sample = out_sample;
  assign out_data.last_sample = (oidx == 6'd63);

  // state, output index and phase
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      oidx  <= '0;
      ph    <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        ST_IDLE: begin
          oidx <= '0;
          ph   <= '0;
        end
        ST_ROWS: begin
          if (ph == PhLast) begin
            ph   <= '0;
            oidx <= oidx + 1'b1;
          end else begin
            ph <= ph + 1'b1;
          end
        end
        ST_COLS: ph <= (ph == PhLast) ? 4'd0 : ph + 1'b1;
        ST_EMIT: if (pop) oidx <= oidx + 1'b1;
        default: ;
      endcase
    end
  end

  // coefficient store writes
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && q_valid) begin
      cstore[q_data.position] <= q_data.coeff_value;
    end
  end

  // written marks, dropped once the row pass has read the block
  always_ff @(posedge clk) begin
    if (rst) begin
      cvalid <= '0;
    end else if (row_done && oidx == 6'd63) begin
      cvalid <= '0;
    end else if (state == ST_IDLE && q_valid) begin
      cvalid[q_data.position] <= 1'b1;
    end
  end

  // registered operand read, unwritten coefficients read as zero
  always_ff @(posedge clk) begin
    if (state == ST_ROWS) begin
      rd_data <= cvalid[caddr] ? RowW'(cstore[caddr]) : '0;
    end else begin
      rd_data <= rstore[raddr];
    end
    rd_n <= ph[2:0];
  end

  // multiply-accumulate over the eight operands
  always_ff @(posedge clk) begin
    if (mac_en) begin
      acc <= ((ph == 4'd1) ? acc_t'(0) : acc) + acc_t'(prod);
    end
  end

  // row pass results and output sample
  always_ff @(posedge clk) begin
    if (row_done) begin
      rstore[oidx] <= row_round[RowW-1:0];
    end
    if (col_done) begin
      out_sample <= col_sat;
    end
  end
endmodule

// ===== sv/integer_idct_8x8.sv =====
// throughput: one coefficient beat per cycle while idle; the row pass, the column pass and
// the samples all run on the one shared mac, so the next block is read in only once the
// last sample of the current block has been popped
// reset: rst synchronous, clears queue, sequencer and coefficient written marks
// top level, depends on idct_pkg, idct_front, idct_engine
module integer_idct_8x8 import idct_pkg::*; #(
  parameter int FifoDepth = FifoDepthDefault
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  output logic      full,
  input  in_item_t  in_data,
  output logic      empty,
  input  logic      pop,
  output out_item_t out_data
);
  logic     q_valid, q_take;
  in_item_t q_data;

  idct_front #(.Depth(FifoDepth)) u_front (
    .clk, .rst, .push, .full, .in_data, .q_valid, .q_take, .q_data
  );

  idct_engine u_engine (
    .clk, .rst, .q_valid, .q_take, .q_data, .empty, .pop, .out_data
  );
endmodule

// ===== sv/idct_checker.sv =====
// port-level checks for integer_idct_8x8
// depends on idct_pkg
module idct_checker import idct_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      push,
  input logic      full,
  input in_item_t  in_data,
  input logic      empty,
  input logic      pop,
  input out_item_t out_data
);
  a_rst_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("not empty after reset");
  a_rst_notfull: assert property (@(posedge clk) rst |=> !full)
    else $error("full after reset");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(out_data)))
    else $error("result changed while stalled");
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (!empty && pop && out_data.last_sample) |=> empty)
    else $error("output continued after last sample");
endmodule

bind integer_idct_8x8 idct_checker u_checker (.*);

// ===== tb/testbench.sv =====
// self-checking testbench for integer_idct_8x8: directed table, saturation block, then random blocks
// depends on idct_pkg and the integer_idct_8x8 rtl
module testbench;
  import idct_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 2000000;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      push = 1'b0;
  logic      pop = 1'b0;
  logic      full, empty;
  in_item_t  in_data = '0;
  out_item_t out_data;

  integer_idct_8x8 dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .in_data(in_data),
    .empty(empty), .pop(pop), .out_data(out_data)
  );

  // clock
  initial begin
    forever #4 clk = ~clk;
  end

  // predictor state
  longint    coeff_grid [64];
  out_item_t sample_queue [$];
  int        mismatch_count = 0;
  int        cycle_count = 0;
  bit        no_stall = 1'b0;
  bit        pop_enable = 1'b0;

  // directed rows: value, position, end flag, typed-in sample check
  typedef struct {
    int  value;
    int  pos;
    bit  last;
    bit  has_fixed;
    int  fixed_sample;
  } stim_row_t;

  stim_row_t stim_table [$];
  int        fixed_queue [$];
  bit        fixed_valid [$];

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d want %0d", what, got, want);
    mismatch_count++;
  endtask

  function automatic longint round_shift(input longint x, input int n);
    return (x + (longint'(1) <<< (n - 1))) >>> n;
  endfunction

  // one-dimensional loeffler pass with rounding descale
  function automatic void loeffler_1d(input longint s [8], input int sh, output longint r [8]);
    longint z1, t0, t1, t2, t3, e0, e1, e2, e3, a1, a2, a3, a4, a5, o0, o1, o2, o3;
    z1 = (s[2] + s[6]) * 4433;
    t2 = z1 - s[6] * 15137;
    t3 = z1 + s[2] * 6270;
    t0 = (s[0] + s[4]) * 8192;
    t1 = (s[0] - s[4]) * 8192;
    e0 = t0 + t3; e3 = t0 - t3; e1 = t1 + t2; e2 = t1 - t2;
    a1 = s[7] + s[1]; a2 = s[5] + s[3]; a3 = s[7] + s[3]; a4 = s[5] + s[1];
    a5 = (a3 + a4) * 9633;
    o0 = s[7] * 2446; o1 = s[5] * 16819; o2 = s[3] * 25172; o3 = s[1] * 12299;
    a1 = a1 * -7373; a2 = a2 * -20995;
    a3 = a3 * -16069 + a5; a4 = a4 * -3196 + a5;
    o0 += a1 + a3; o1 += a2 + a4; o2 += a2 + a3; o3 += a1 + a4;
    r[0] = round_shift(e0 + o3, sh); r[7] = round_shift(e0 - o3, sh);
    r[1] = round_shift(e1 + o2, sh); r[6] = round_shift(e1 - o2, sh);
    r[2] = round_shift(e2 + o1, sh); r[5] = round_shift(e2 - o1, sh);
    r[3] = round_shift(e3 + o0, sh); r[4] = round_shift(e3 - o0, sh);
  endfunction

  // store a coefficient beat; on end of block transform and queue 64 samples
  task automatic predict_block(input in_item_t beat);
    longint    s [8], r [8], rows [64], v;
    out_item_t o;
    coeff_grid[beat.position] = longint'(beat.coeff_value);
    if (beat.end_block) begin
      for (int i = 0; i < 8; i++) begin
        for (int j = 0; j < 8; j++) s[j] = coeff_grid[i*8+j];
        loeffler_1d(s, RowShift, r);
        for (int j = 0; j < 8; j++) rows[i*8+j] = r[j];
      end
      for (int k = 0; k < 64; k++) sample_queue.push_back('0);
      for (int j = 0; j < 8; j++) begin
        for (int i = 0; i < 8; i++) s[i] = rows[i*8+j];
        loeffler_1d(s, ColShift, r);
        for (int i = 0; i < 8; i++) begin
          v = r[i];
          if (v > 32767) v = 32767;
          if (v < -32768) v = -32768;
          o.sample = v[15:0];
          o.last_sample = (i*8+j == 63);
          sample_queue[sample_queue.size() - 64 + i*8 + j] = o;
        end
      end
      for (int k = 0; k < 64; k++) coeff_grid[k] = 0;
    end
  endtask

  // drive one beat, idling at random; push stays high into the next beat
  task automatic send_beat(input int value, input int pos, input bit last);
    in_item_t beat;
    beat.coeff_value = value[11:0];
    beat.position    = pos[5:0];
    beat.end_block   = last;
    while (!no_stall && $urandom_range(99) < 35) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push    <= 1'b1;
    in_data <= beat;
    @(posedge clk);
    while (full) @(posedge clk);
    predict_block(beat);
  endtask

  function automatic int rand_coeff();
    case ($urandom_range(3))
      0: return $urandom_range(4095) - 2048;
      1: return $urandom_range(1) ? 2047 : -2048;
      default: return int'($urandom_range(64)) - 32;
    endcase
  endfunction

  // result side: pop at random and compare with the oldest expectation
  always @(posedge clk) begin
    if (!rst) begin
      if (pop && !empty) begin
        if (sample_queue.size() == 0) begin
          report_mismatch("unexpected sample", out_data.sample, 0);
        end else begin
          out_item_t want;
          want = sample_queue.pop_front();
          if (out_data.sample !== want.sample)
            report_mismatch("sample", out_data.sample, want.sample);
          if (out_data.last_sample !== want.last_sample)
            report_mismatch("last_sample", out_data.last_sample, want.last_sample);
          if (fixed_queue.size() > 0) begin
            int fv;
            bit ok;
            fv = fixed_queue.pop_front();
            ok = fixed_valid.pop_front();
            if (ok && out_data.sample !== fv[15:0])
              report_mismatch("fixed sample", out_data.sample, fv);
          end
        end
      end
      pop <= pop_enable && (no_stall || $urandom_range(99) >= 35);
    end
  end

  // cycle limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // stimulus
  initial begin
    int nblk, sent;
    for (int k = 0; k < 64; k++) coeff_grid[k] = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    pop_enable <= 1'b1;
    @(posedge clk);

    // directed: empty block is all zero, dc extremes, corner and scattered positions, overwrite
    stim_table.push_back('{0, 0, 1'b1, 1'b1, 0});
    stim_table.push_back('{2047, 0, 1'b1, 1'b0, 0});
    stim_table.push_back('{-2048, 0, 1'b1, 1'b0, 0});
    stim_table.push_back('{-2048, 63, 1'b1, 1'b0, 0});
    stim_table.push_back('{2047, 9, 1'b0, 1'b0, 0});
    stim_table.push_back('{-2048, 9, 1'b0, 1'b0, 0});
    stim_table.push_back('{5, 18, 1'b1, 1'b0, 0});
    stim_table.push_back('{-1, 27, 1'b0, 1'b0, 0});
    stim_table.push_back('{1365, 42, 1'b0, 1'b0, 0});
    stim_table.push_back('{-1366, 21, 1'b0, 1'b0, 0});
    stim_table.push_back('{2047, 7, 1'b0, 1'b0, 0});
    stim_table.push_back('{-2048, 56, 1'b0, 1'b0, 0});
    stim_table.push_back('{2047, 36, 1'b1, 1'b0, 0});
    foreach (stim_table[n]) begin
      if (stim_table[n].last)
        for (int k = 0; k < 64; k++) begin
          fixed_queue.push_back(stim_table[n].fixed_sample);
          fixed_valid.push_back(stim_table[n].has_fixed);
        end
      send_beat(stim_table[n].value, stim_table[n].pos, stim_table[n].last);
    end

    // saturation: all coefficients at extremes, every third one positive
    for (int k = 0; k < 64; k++) send_beat(((k % 3) == 0) ? 2047 : -2048, k, k == 63);
    push <= 1'b0;

    // hold off until every sample has come back
    while (sample_queue.size() != 0) @(posedge clk);

    // random blocks of sparse writes, some dense, one stretch with no idling
    sent = 0;
    nblk = 0;
    while (sent < 175) begin
      int nwr;
      no_stall = (nblk >= 3 && nblk < 6);
      nwr = ($urandom_range(9) == 0) ? $urandom_range(64, 40) : $urandom_range(12, 1);
      for (int k = 0; k < nwr; k++) begin
        send_beat(rand_coeff(), $urandom_range(63), k == nwr - 1);
        sent++;
      end
      nblk++;
    end
    push <= 1'b0;
    no_stall = 1'b0;

    while (sample_queue.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
